[sv/bre_pkg.sv]
`timescale 1ns / 1ps
package bre_pkg;

  localparam int MAP_BITS_DEF  = 4096;
  localparam int WORD_BITS_DEF = 64;

  // field widths of a request and a result
  localparam int REQ_W   = 3;
  localparam int START_W = 12;
  localparam int COUNT_W = 13;
  localparam int LIMIT_W = 13;
  localparam int INDEX_W = 13;
  localparam int END_W   = 14;

  localparam logic [REQ_W-1:0] REQ_SET        = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TEST_SET   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TEST_CLEAR = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FIND_SET   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_FIND_ZERO  = 3'd5;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic hit;
    logic last;
  } scan_stat_t;

  typedef struct packed {
    logic [INDEX_W-1:0] found_index;
    logic               all_match;
    logic               range_error;
  } result_t;

endpackage

[sv/bre_ram.sv]
`timescale 1ns / 1ps
module bre_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/bre_word_unit.sv]
`timescale 1ns / 1ps
module bre_word_unit import bre_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int BASE_W = END_W,
  localparam int POS_W = $clog2(WORD_BITS),
  localparam int OFF_W = $clog2(WORD_BITS + 1)
) (
  input  logic [REQ_W-1:0]     req,
  input  logic [WORD_BITS-1:0] data,
  input  logic [BASE_W-1:0]    base,
  input  logic [BASE_W-1:0]    lo,
  input  logic [BASE_W-1:0]    hi,
  output logic [WORD_BITS-1:0] new_word,
  output scan_stat_t           stat,
  output logic [POS_W-1:0]     hit_pos
);

  logic [BASE_W-1:0]    top;
  logic [OFF_W-1:0]     lo_off;
  logic [OFF_W-1:0]     hi_off;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] sel;
  logic [WORD_BITS-1:0] hits;
  logic [WORD_BITS-1:0] lowest;

  assign top = base + BASE_W'(WORD_BITS);

  // window of the range inside this word
  always_comb begin
    if (lo <= base) begin
      lo_off = '0;
    end else if (lo >= top) begin
      lo_off = OFF_W'(WORD_BITS);
    end else begin
      lo_off = OFF_W'(lo - base);
    end
    if (hi >= top) begin
      hi_off = OFF_W'(WORD_BITS);
    end else if (hi <= base) begin
      hi_off = '0;
    end else begin
      hi_off = OFF_W'(hi - base);
    end
  end

  always_comb begin
    for (int p = 0; p < WORD_BITS; p++) begin
      mask[p] = (OFF_W'(p) >= lo_off) && (OFF_W'(p) < hi_off);
    end
  end

  // hits are mismatches for tests and targets for finds
  assign sel    = (req == REQ_TEST_SET || req == REQ_FIND_ZERO) ? ~data : data;
  assign hits   = sel & mask;
  assign lowest = hits & (~hits + WORD_BITS'(1));

  always_comb begin
    hit_pos = '0;
    for (int p = 0; p < WORD_BITS; p++) begin
      if (lowest[p]) begin
        hit_pos = hit_pos | POS_W'(p);
      end
    end
  end

  assign new_word  = (req == REQ_SET) ? (data | mask) : (data & ~mask);
  assign stat.hit  = |hits;
  assign stat.last = (top >= hi);

endmodule

[sv/bre_seq.sv]
`timescale 1ns / 1ps
module bre_seq import bre_pkg::*; #(
  parameter int MAP_BITS = MAP_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int WORD_COUNT = (MAP_BITS + WORD_BITS - 1) / WORD_BITS,
  localparam int ADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [START_W-1:0]   start_bit,
  input  logic [COUNT_W-1:0]   bit_count,
  input  logic [LIMIT_W-1:0]   search_limit,
  output logic                 res_valid,
  input  logic                 res_ready,
  output result_t              res,
  output logic                 rd_en,
  output logic [ADDR_W-1:0]    rd_addr,
  input  logic [WORD_BITS-1:0] rd_data,
  output logic                 wr_en,
  output logic [ADDR_W-1:0]    wr_addr,
  output logic [WORD_BITS-1:0] wr_data
);

  localparam int SPAN_W = $clog2((WORD_COUNT + 1) * WORD_BITS + 1);
  localparam int BASE_W = (SPAN_W > END_W) ? SPAN_W : END_W;
  localparam int POS_W  = $clog2(WORD_BITS);

  state_t              state, state_next;
  logic [REQ_W-1:0]    req, req_next;
  logic [BASE_W-1:0]   lo, lo_next;
  logic [BASE_W-1:0]   hi, hi_next;
  logic [BASE_W-1:0]   base, base_next;
  logic [ADDR_W-1:0]   cur, cur_next;
  result_t             res_next;

  logic [BASE_W-1:0]    end_sum;
  logic [BASE_W-1:0]    lim;
  logic                 is_range;
  logic                 is_find;
  logic                 is_test;
  logic                 range_bad;
  logic                 go_scan;
  logic                 take;
  logic                 stop;
  logic [WORD_BITS-1:0] new_word;
  scan_stat_t           stat;
  logic [POS_W-1:0]     hit_pos;

  bre_word_unit #(
    .WORD_BITS (WORD_BITS),
    .BASE_W    (BASE_W)
  ) u_unit (
    .req      (req),
    .data     (rd_data),
    .base     (base),
    .lo       (lo),
    .hi       (hi),
    .new_word (new_word),
    .stat     (stat),
    .hit_pos  (hit_pos)
  );

  // request decode
  assign end_sum   = BASE_W'(start_bit) + BASE_W'(bit_count);
  assign lim       = (BASE_W'(search_limit) > BASE_W'(MAP_BITS)) ?
                     BASE_W'(MAP_BITS) : BASE_W'(search_limit);
  assign is_range  = (req_type <= REQ_TEST_CLEAR);
  assign is_test   = (req_type == REQ_TEST_SET) || (req_type == REQ_TEST_CLEAR);
  assign is_find   = (req_type == REQ_FIND_SET) || (req_type == REQ_FIND_ZERO);
  assign range_bad = (end_sum > BASE_W'(MAP_BITS));
  assign go_scan   = is_range ? (!range_bad && (bit_count != '0)) :
                     is_find  ? (BASE_W'(start_bit) < lim) : 1'b0;
  assign take      = in_valid && in_ready;
  // set and clear never stop early
  assign stop      = stat.last || (stat.hit && (req >= REQ_TEST_SET));

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (cur == ADDR_W'(WORD_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take) begin
          state_next = go_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (stop) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    res_valid = (state == ST_DONE);
    req_next  = req;
    lo_next   = lo;
    hi_next   = hi;
    base_next = base;
    cur_next  = cur;
    res_next  = res;
    rd_en     = 1'b0;
    rd_addr   = cur + ADDR_W'(1);
    wr_en     = 1'b0;
    wr_addr   = cur;
    wr_data   = new_word;
    case (state)
      ST_CLEAR: begin
        wr_en    = 1'b1;
        wr_data  = '0;
        cur_next = cur + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (take) begin
          req_next              = req_type;
          lo_next               = BASE_W'(start_bit);
          hi_next               = is_find ? lim : end_sum;
          base_next             = '0;
          cur_next              = '0;
          res_next.found_index  = is_find ? INDEX_W'(lim) : '0;
          res_next.all_match    = is_test && !range_bad;
          res_next.range_error  = is_range && range_bad;
          rd_en                 = go_scan;
          rd_addr               = '0;
        end
      end
      ST_SCAN: begin
        wr_en = (req == REQ_SET) || (req == REQ_CLEAR);
        if (stat.hit) begin
          if (req == REQ_TEST_SET || req == REQ_TEST_CLEAR) begin
            res_next.all_match = 1'b0;
          end
          if (req == REQ_FIND_SET || req == REQ_FIND_ZERO) begin
            res_next.found_index = INDEX_W'(base + BASE_W'(hit_pos));
          end
        end
        if (!stop) begin
          rd_en     = 1'b1;
          cur_next  = cur + ADDR_W'(1);
          base_next = base + BASE_W'(WORD_BITS);
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cur   <= '0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
    end
    req  <= req_next;
    lo   <= lo_next;
    hi   <= hi_next;
    base <= base_next;
    res  <= res_next;
  end

`ifndef NO_ASSERTIONS
  a_err_reported: assert property (@(posedge clk) disable iff (rst)
    (take && is_range && range_bad) |=> (res_valid && res.range_error))
    else $error("range past map end not reported");

  a_base_tracks_word: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (base == BASE_W'(cur) * BASE_W'(WORD_BITS)))
    else $error("scan base out of step with word index");

  a_found_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.found_index <= MAP_BITS))
    else $error("found index beyond map");

  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.range_error) |-> (!res.all_match && res.found_index == '0))
    else $error("range error with other result fields set");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !wr_en)
    else $error("map written while idle");
`endif

endmodule

[sv/bitmap_range_engine_top.sv]
`timescale 1ns / 1ps
// Allocation bitmap of MAP_BITS bits held in a RAM of MAP_BITS/WORD_BITS words. Each
// request sets or clears a run of bits, tests a run for all set or all clear, or finds
// the first set or zero bit at or after start_bit and below the (saturated) search
// limit; exactly one result transfer comes back per request. A request is served by
// one shared word unit that walks the map one word per cycle from word 0 up to the word
// holding the last bit of the range; the RAM's single read port sets that pace. The
// result is then held in the done state until the output register takes it, and the
// next request is taken only once the engine is back in idle, so no request is taken
// while another is in progress. Tests and finds stop at the first deciding word.
// Requests that fail the range check, empty runs, finds whose start is at or past the
// limit and unused codes skip the walk and have their result in the cycle after being
// taken. After reset the map is zeroed by a pass that writes every word, during which
// no request is taken. One finished result can wait in the output register while the
// next request is taken.
module bitmap_range_engine_top import bre_pkg::*; #(
  parameter int MAP_BITS = MAP_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // req_type[2:0], start_bit[14:3], bit_count[27:15], search_limit[40:28], zero fill
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // found_index[12:0], all_match[13], range_error[14], zero fill
  output logic [15:0] m_tdata
);

  localparam int WORD_COUNT = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  logic                 res_valid;
  logic                 res_ready;
  result_t              res;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 out_valid, out_valid_next;
  result_t              out_res, out_res_next;

  bre_seq #(
    .MAP_BITS  (MAP_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .req_type     (s_tdata[2:0]),
    .start_bit    (s_tdata[14:3]),
    .bit_count    (s_tdata[27:15]),
    .search_limit (s_tdata[40:28]),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  bre_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_map (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // output register, refilled in the cycle it drains
  assign res_ready = !out_valid || m_tready;

  always_comb begin
    out_valid_next = out_valid;
    out_res_next   = out_res;
    if (m_tready) begin
      out_valid_next = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_next = 1'b1;
      out_res_next   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
    out_res <= out_res_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res.range_error, out_res.all_match, out_res.found_index};

endmodule
